// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== hw/rtl/tbdp_pkg.sv =====
// Types, constants and helper functions for the tournament branch predictor.
package tbdp_pkg;

    localparam int BIMODAL_ENTRIES = 65536;
    localparam int CHOOSER_ENTRIES = 65536;
    localparam int PATTERN_ENTRIES = 65536;
    localparam int HIST_BITS       = 16;

    localparam int BIM_IDX_W = $clog2(BIMODAL_ENTRIES);
    localparam int CHO_IDX_W = $clog2(CHOOSER_ENTRIES);
    localparam int PAT_IDX_W = $clog2(PATTERN_ENTRIES);
    localparam int CLR_W_BC  = (BIM_IDX_W > CHO_IDX_W) ? BIM_IDX_W : CHO_IDX_W;
    localparam int CLR_W     = (CLR_W_BC > PAT_IDX_W) ? CLR_W_BC : PAT_IDX_W;

    localparam int ADDR_W       = 64;
    localparam int FOLD_SHIFT   = 16;
    localparam int SAVED_IDX_W  = 16;
    localparam int CTR_W        = 2;

    localparam logic [CTR_W-1:0] CTR_INIT = 2'd1;
    localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN  = 2'd0;

    // Slave tdata layout
    localparam int S_ADDR_LSB   = 0;
    localparam int S_TAKEN_BIT  = 64;
    localparam int S_IDX_LSB    = 65;
    localparam int S_BG_BIT     = 81;
    localparam int S_TG_BIT     = 82;
    localparam int S_TDATA_W    = 88;

    // Master tdata layout
    localparam int M_PRED_BIT   = 0;
    localparam int M_CHOSE_BIT  = 1;
    localparam int M_BG_BIT     = 2;
    localparam int M_TG_BIT     = 3;
    localparam int M_IDX_LSB    = 4;
    localparam int M_TDATA_W    = 24;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef enum logic {
        CMD_PREDICT = 1'b0,
        CMD_RESOLVE = 1'b1
    } cmd_t;

    localparam logic REG_HIST_MODE = 1'b0;

    function automatic logic [CTR_W-1:0] train(input logic [CTR_W-1:0] ctr, input logic up);
        logic [CTR_W-1:0] res;
        if (up)
            res = (ctr == CTR_MAX) ? CTR_MAX : ctr + 1'b1;
        else
            res = (ctr == CTR_MIN) ? CTR_MIN : ctr - 1'b1;
        return res;
    endfunction

endpackage

// ===== hw/rtl/tournament_branch_direction_predictor_unit.sv =====
// Top level of the tournament (bimodal + gshare) branch direction predictor.
// A request is taken in the idle state, whose accept edge launches the reads of the
// bimodal, chooser and pattern RAMs; in the lookup state that follows, the
// prediction is loaded into the result register or the trained counters are
// written back, as the counter RAMs give registered read data. A predict also
// waits in the lookup state while an earlier result still sits unaccepted in the
// result register. After reset a clearing pass writes every counter to
// weakly-not-taken, one entry of each RAM per cycle; s_tready stays low during
// it while APB writes are taken as usual. History resets to zero,
// history_xor_mode to 1.
module tournament_branch_direction_predictor_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata, low bit up: branch_addr[63:0], actual_taken, saved_twolevel_index[15:0],
    // saved_bimodal_guess, saved_twolevel_guess, zero pad
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tbdp_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: cmd (0 predict, 1 resolve)
    input  logic                            s_tuser,
    // m_tdata, low bit up: predicted_taken, chose_twolevel, bimodal_guess,
    // twolevel_guess, twolevel_index[15:0], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tbdp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbdp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbdp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbdp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    import tbdp_pkg::*;

    state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [HIST_BITS-1:0] hist_reg, hist_next;
    logic xor_mode_reg;

    // latched request
    cmd_t                 cmd_reg;
    logic                 taken_reg, sbg_reg, stg_reg;
    logic [BIM_IDX_W-1:0] bim_idx_reg;
    logic [CHO_IDX_W-1:0] cho_idx_reg;
    logic [PAT_IDX_W-1:0] pat_idx_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    // RAM ports
    logic                 bim_we, cho_we, pat_we, rd_en;
    logic [BIM_IDX_W-1:0] bim_waddr;
    logic [CHO_IDX_W-1:0] cho_waddr;
    logic [PAT_IDX_W-1:0] pat_waddr;
    logic [CTR_W-1:0]     bim_wdata, cho_wdata, pat_wdata;
    logic [CTR_W-1:0]     bim_rdata, cho_rdata, pat_rdata;

    logic                 in_accept, cfg_write, load_out;
    logic [ADDR_W-1:0]    in_addr, folded, pat_raw;
    logic [BIM_IDX_W-1:0] bim_idx;
    logic [CHO_IDX_W-1:0] cho_idx;
    logic [PAT_IDX_W-1:0] pat_idx;
    logic [31:0]          saved_idx_ext, out_idx_ext;
    logic                 bg, tg, ch;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == REG_HIST_MODE) ? {{(APB_DATA_W-1){1'b0}}, xor_mode_reg}
                                                   : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xor_mode_reg <= 1'b1;
        else if (cfg_write && paddr[2] == REG_HIST_MODE)
            xor_mode_reg <= pwdata[0];
    end

    // ---------------- index hashing ----------------
    assign in_addr   = s_tdata[S_ADDR_LSB +: ADDR_W];
    assign folded    = (in_addr >> FOLD_SHIFT) ^ in_addr;
    assign bim_idx   = folded[BIM_IDX_W-1:0];
    assign cho_idx   = folded[CHO_IDX_W-1:0];
    // gshare index, or history with the address above it
    assign pat_raw   = xor_mode_reg
                     ? ({{(ADDR_W-HIST_BITS){1'b0}}, hist_reg} ^ in_addr)
                     : ({{(ADDR_W-HIST_BITS){1'b0}}, hist_reg} | (in_addr << HIST_BITS));
    assign saved_idx_ext = {{(32-SAVED_IDX_W){1'b0}}, s_tdata[S_IDX_LSB +: SAVED_IDX_W]};
    assign pat_idx   = (cmd_t'(s_tuser) == CMD_RESOLVE) ? saved_idx_ext[PAT_IDX_W-1:0]
                                                         : pat_raw[PAT_IDX_W-1:0];

    assign in_accept = s_tvalid & s_tready;

    // component guesses from the RAM read data
    assign bg = bim_rdata[CTR_W-1];
    assign tg = pat_rdata[CTR_W-1];
    assign ch = cho_rdata[CTR_W-1];

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == {CLR_W{1'b1}})
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_accept)
                    state_next = ST_LOOKUP;
            ST_LOOKUP:
                if (cmd_reg == CMD_RESOLVE || !out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        rd_en        = 1'b0;
        load_out     = 1'b0;
        bim_we       = 1'b0;
        cho_we       = 1'b0;
        pat_we       = 1'b0;
        bim_waddr    = bim_idx_reg;
        cho_waddr    = cho_idx_reg;
        pat_waddr    = pat_idx_reg;
        bim_wdata    = train(bim_rdata, taken_reg);
        pat_wdata    = train(pat_rdata, taken_reg);
        cho_wdata    = train(cho_rdata, stg_reg == taken_reg);
        hist_next    = hist_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                bim_we       = 1'b1;
                cho_we       = 1'b1;
                pat_we       = 1'b1;
                bim_waddr    = clr_cnt_reg[BIM_IDX_W-1:0];
                cho_waddr    = clr_cnt_reg[CHO_IDX_W-1:0];
                pat_waddr    = clr_cnt_reg[PAT_IDX_W-1:0];
                bim_wdata    = CTR_INIT;
                cho_wdata    = CTR_INIT;
                pat_wdata    = CTR_INIT;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                rd_en    = in_accept;
            end
            ST_LOOKUP:
            begin
                if (cmd_reg == CMD_RESOLVE)
                begin
                    bim_we    = 1'b1;
                    pat_we    = 1'b1;
                    // chooser learns only when the components disagreed
                    cho_we    = (sbg_reg != stg_reg);
                    hist_next = {hist_reg[HIST_BITS-2:0], taken_reg};
                end
                else
                begin
                    load_out = !out_valid_reg || m_tready;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------- result register ----------------
    assign out_idx_ext    = {{(32-PAT_IDX_W){1'b0}}, pat_idx_reg};
    assign out_valid_next = load_out | (out_valid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            hist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hist_reg      <= hist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg     <= cmd_t'(s_tuser);
            taken_reg   <= s_tdata[S_TAKEN_BIT];
            sbg_reg     <= s_tdata[S_BG_BIT];
            stg_reg     <= s_tdata[S_TG_BIT];
            bim_idx_reg <= bim_idx;
            cho_idx_reg <= cho_idx;
            pat_idx_reg <= pat_idx;
        end
        if (load_out)
        begin
            // index, two-level guess, bimodal guess, chooser, chosen direction
            out_data_reg <= {{(M_TDATA_W-M_IDX_LSB-SAVED_IDX_W){1'b0}},
                             out_idx_ext[SAVED_IDX_W-1:0], tg, bg, ch, ch ? tg : bg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- counter RAMs ----------------
    tbdp_ram #(.WIDTH(CTR_W), .DEPTH(BIMODAL_ENTRIES)) u_bim_ram (
        .clk   (clk),
        .we    (bim_we),
        .waddr (bim_waddr),
        .wdata (bim_wdata),
        .re    (rd_en),
        .raddr (bim_idx),
        .rdata (bim_rdata)
    );

    tbdp_ram #(.WIDTH(CTR_W), .DEPTH(CHOOSER_ENTRIES)) u_cho_ram (
        .clk   (clk),
        .we    (cho_we),
        .waddr (cho_waddr),
        .wdata (cho_wdata),
        .re    (rd_en),
        .raddr (cho_idx),
        .rdata (cho_rdata)
    );

    tbdp_ram #(.WIDTH(CTR_W), .DEPTH(PATTERN_ENTRIES)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .re    (rd_en),
        .raddr (pat_idx),
        .rdata (pat_rdata)
    );

endmodule

// ===== hw/rtl/tbdp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tbdp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tbdp_checker.sv =====
// Port-level checker for the tournament branch predictor, bound to the top level.
`include "assert_macros.svh"

module tbdp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tbdp_pkg::M_TDATA_W-1:0] m_tdata
);

    import tbdp_pkg::*;

    // one request in flight: no accept on the cycle after an accept
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready, "accept right after accept")

    // a resolve never produces a result
    `ASSERT_IMPL(a_resolve_silent, clk, rst_n, s_tvalid && s_tready && s_tuser && !m_tvalid, ##2 !m_tvalid, "result after resolve")

    // a fresh result always traces back to an accepted predict request
    `ASSERT_IMPL(a_result_origin, clk, rst_n, $rose(m_tvalid), $past(s_tvalid && s_tready && !s_tuser, 2), "result without predict")

    // stalled result holds
    `ASSERT_NEXT(a_result_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind tournament_branch_direction_predictor_unit tbdp_checker u_tbdp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tournament_branch_direction_predictor_unit_tb.sv =====
// Self-checking bench for the tournament branch direction predictor: stream, APB, scoreboard.
`timescale 1ns / 1ps

module tournament_branch_direction_predictor_unit_tb;
    import tbdp_pkg::*;

    // A resolve leaves nothing on the result side, so after the last result
    // we still let the block settle before touching the register.
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    // Beyond the clearing pass, the run is ~1450 requests with gaps and stalls.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 120;
    localparam int HOT_COUNT     = 12;
    localparam int MAX_UNRESOLVED = 4;

    // Register byte addresses (register index times four).
    localparam logic [APB_ADDR_W-1:0] HIST_MODE_ADDR = APB_ADDR_W'(REG_HIST_MODE) << 2;
    localparam logic [APB_ADDR_W-1:0] SPARE_REG_ADDR = 3'd4;

    // One prediction as it leaves the block.
    typedef struct packed {
        logic        pred;
        logic        chose;
        logic        bg;
        logic        tg;
        logic [15:0] idx;
    } verdict_t;

    // One request on the slave side, plus bench-only bookkeeping.
    typedef struct {
        cmd_t        cmd;
        logic [63:0] addr;
        logic        taken;
        logic [15:0] idx;
        logic        bg;
        logic        tg;
        bit          typed;   // directed row carries its own expected verdict
        verdict_t    want;
        int unsigned bias;    // taken probability in percent, used when resolving
    } request_t;

    // A predict that was accepted and has not been resolved yet.
    typedef struct {
        logic [63:0] addr;
        verdict_t    v;
        int unsigned bias;
    } open_branch_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state, kept in acceptance order by the monitor.
    logic [1:0]   bim_ctr [0:65535];
    logic [1:0]   cho_ctr [0:65535];
    logic [1:0]   pat_ctr [0:65535];
    logic [15:0]  ghist;
    logic         xor_mode;

    verdict_t     due_verdicts[$];
    open_branch_t unresolved[$];
    request_t     dir_tab[$];
    request_t     offered;

    logic [63:0]  hot_addr [HOT_COUNT];
    int unsigned  hot_bias [HOT_COUNT];

    int  mismatch_cnt;
    int  results_seen;
    int  cycles;
    bit  no_idle;
    bit  long_hold_done;

    tournament_branch_direction_predictor_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Bimodal and chooser slot: fold address bits 31:16 onto the low 16 bits.
    function automatic logic [15:0] fold_slot(input logic [63:0] addr);
        logic [63:0] f;
        f = (addr >> FOLD_SHIFT) ^ addr;
        return f[15:0];
    endfunction

    function automatic logic [1:0] bump(input logic [1:0] ctr, input logic up);
        if (up)
            return (ctr == 2'd3) ? 2'd3 : ctr + 2'd1;
        return (ctr == 2'd0) ? 2'd0 : ctr - 2'd1;
    endfunction

    function automatic verdict_t predict_branch(input logic [63:0] addr);
        verdict_t    v;
        logic [15:0] slot;
        slot = fold_slot(addr);
        // Concatenated mode: address lands above the 16 history bits and is
        // masked off again by the 64K table, so only history is left.
        v.idx   = xor_mode ? (ghist ^ addr[15:0]) : ghist;
        v.bg    = bim_ctr[slot][1];
        v.tg    = pat_ctr[v.idx][1];
        v.chose = cho_ctr[slot][1];
        v.pred  = v.chose ? v.tg : v.bg;
        return v;
    endfunction

    task automatic train_branch(input request_t r);
        logic [15:0] slot;
        slot = fold_slot(r.addr);
        ghist = {ghist[14:0], r.taken};
        bim_ctr[slot] = bump(bim_ctr[slot], r.taken);
        pat_ctr[r.idx] = bump(pat_ctr[r.idx], r.taken);
        // chooser only learns when the components disagreed
        if (r.bg != r.tg)
            cho_ctr[slot] = bump(cho_ctr[slot], r.tg == r.taken);
    endtask

    task automatic reset_model();
        for (int k = 0; k < 65536; k++)
        begin
            bim_ctr[k] = 2'd1;
            cho_ctr[k] = 2'd1;
            pat_ctr[k] = 2'd1;
        end
        ghist    = '0;
        xor_mode = 1'b1;
    endtask

    // Work out what an accepted request causes.
    task automatic apply_request(input request_t r);
        verdict_t     v;
        open_branch_t ob;
        if (r.cmd == CMD_PREDICT)
        begin
            v = predict_branch(r.addr);
            due_verdicts.push_back(r.typed ? r.want : v);
            ob.addr = r.addr;
            ob.v    = v;
            ob.bias = r.bias;
            unresolved.push_back(ob);
            if (unresolved.size() > 2 * MAX_UNRESOLVED)
                void'(unresolved.pop_front());
        end
        else
        begin
            train_branch(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
    endtask

    // Results are checked before the new request is applied; since a request passes
    // idle and lookup before its result is loaded, the two can never belong to the same item on one edge.
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.pred  = m_tdata[M_PRED_BIT];
                got.chose = m_tdata[M_CHOSE_BIT];
                got.bg    = m_tdata[M_BG_BIT];
                got.tg    = m_tdata[M_TG_BIT];
                got.idx   = m_tdata[M_IDX_LSB +: 16];
                results_seen++;
                if (due_verdicts.size() == 0)
                begin
                    note_mismatch("unexpected result", '0, 32'(m_tdata));
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    if (got.pred !== want.pred)
                        note_mismatch("predicted_taken", 32'(want.pred), 32'(got.pred));
                    if (got.chose !== want.chose)
                        note_mismatch("chose_twolevel", 32'(want.chose), 32'(got.chose));
                    if (got.bg !== want.bg)
                        note_mismatch("bimodal_guess", 32'(want.bg), 32'(got.bg));
                    if (got.tg !== want.tg)
                        note_mismatch("twolevel_guess", 32'(want.tg), 32'(got.tg));
                    if (got.idx !== want.idx)
                        note_mismatch("twolevel_index", 32'(want.idx), 32'(got.idx));
                end
            end
            if (s_tvalid && s_tready)
                apply_request(offered);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, one long hold once traffic is going
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                // sender keeps offering; block fills up and drops s_tready
                long_hold_done = 1'b1;
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                m_tready = 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [31:0] d);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = a;
        pwdata  = d;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // only register 0 exists; writes to the spare address 4 are dropped
        if (a == HIST_MODE_ADDR)
            xor_mode = d[0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check_mode();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = HIST_MODE_ADDR;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {31'b0, xor_mode})
            note_mismatch("history_xor_mode readback", {31'b0, xor_mode}, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Advance to the next falling edge, sometimes with an idle burst.
    task automatic pace_sender();
        int gap;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drive at the falling edge, hold until accepted.
    task automatic offer(input request_t r);
        offered  = r;
        s_tuser  = r.cmd;
        s_tdata  = {{(S_TDATA_W - 83){1'b0}}, r.tg, r.bg, r.idx, r.taken, r.addr};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every prediction is back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic request_t row(input cmd_t c, input logic [63:0] a, input logic t,
                                     input logic [15:0] ix, input logic b, input logic g);
        request_t r;
        r.cmd   = c;
        r.addr  = a;
        r.taken = t;
        r.idx   = ix;
        r.bg    = b;
        r.tg    = g;
        r.typed = 1'b0;
        r.want  = '0;
        r.bias  = 50;
        return r;
    endfunction

    function automatic request_t typed_row(input logic [63:0] a, input logic t,
                                           input logic [15:0] ix, input logic b,
                                           input logic g, input verdict_t w);
        request_t r;
        r = row(CMD_PREDICT, a, t, ix, b, g);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    // Mostly well-formed predict/resolve pairs over a small hot set of branches
    // with skewed outcomes; the rest is noise and broken resolves.
    task automatic next_random_request(output request_t r);
        int unsigned  roll;
        int unsigned  k;
        open_branch_t ob;
        roll = $urandom_range(0, 99);
        r = row(CMD_PREDICT, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (roll < 15)
        begin
            // noise: anything at all
            r.cmd = cmd_t'($urandom_range(0, 1));
        end
        else if (roll < 20 && unresolved.size() != 0)
        begin
            // broken resolve: right branch, mangled saved state
            k  = $urandom_range(0, unresolved.size() - 1);
            ob = unresolved[k];
            unresolved.delete(k);
            r.cmd  = CMD_RESOLVE;
            r.addr = ob.addr;
            r.bg   = ob.v.bg ^ 1'($urandom_range(0, 1));
            r.tg   = ob.v.tg ^ 1'($urandom_range(0, 1));
        end
        else if (unresolved.size() >= MAX_UNRESOLVED ||
                 (unresolved.size() != 0 && roll < 55))
        begin
            // resolve, usually in order, sometimes out of order
            k  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, unresolved.size() - 1) : 0;
            ob = unresolved[k];
            unresolved.delete(k);
            r.cmd   = CMD_RESOLVE;
            r.addr  = ob.addr;
            r.idx   = ob.v.idx;
            r.bg    = ob.v.bg;
            r.tg    = ob.v.tg;
            r.taken = ($urandom_range(0, 99) < ob.bias);
        end
        else
        begin
            // predict on a hot branch; resolve-only fields stay random
            k = $urandom_range(0, HOT_COUNT - 1);
            r.addr = hot_addr[k];
            r.bias = hot_bias[k];
        end
    endtask

    task automatic random_phase(input int count, input int pause_at);
        request_t r;
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
                drain_results();
            pace_sender();
            next_random_request(r);
            offer(r);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_PREDICT;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        offered  = row(CMD_PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);
        mismatch_cnt   = 0;
        results_seen   = 0;
        cycles         = 0;
        no_idle        = 1'b0;
        long_hold_done = 1'b0;
        reset_model();

        for (int k = 0; k < HOT_COUNT; k++)
        begin
            hot_addr[k] = {$urandom, $urandom};
            hot_bias[k] = (k % 3 == 0) ? 3 : ((k % 3 == 1) ? 97 : 50);
        end

        // Directed table; history 0 and all counters weakly-not-taken at the top.
        dir_tab.push_back(typed_row(64'h0, 1'b0, 16'h0, 1'b0, 1'b0,
                                    '{pred: 1'b0, chose: 1'b0, bg: 1'b0, tg: 1'b0, idx: 16'h0}));
        dir_tab.push_back(typed_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'h0, 1'b0, 1'b0,
                                    '{pred: 1'b0, chose: 1'b0, bg: 1'b0, tg: 1'b0,
                                      idx: 16'hFFFF}));
        dir_tab.push_back(typed_row(64'h0123_4567_89AB_CDEF, 1'b0, 16'h0, 1'b0, 1'b0,
                                    '{pred: 1'b0, chose: 1'b0, bg: 1'b0, tg: 1'b0,
                                      idx: 16'hCDEF}));
        // predict ignores the resolve-only fields
        dir_tab.push_back(typed_row(64'hA5A5_0000_0000_5A5A, 1'b1, 16'hFFFF, 1'b1, 1'b1,
                                    '{pred: 1'b0, chose: 1'b0, bg: 1'b0, tg: 1'b0,
                                      idx: 16'h5A5A}));
        // agreeing guesses: chooser untouched
        dir_tab.push_back(row(CMD_RESOLVE, 64'h0, 1'b1, 16'h0000, 1'b0, 1'b0));
        dir_tab.push_back(row(CMD_PREDICT, 64'h0, 1'b0, 16'h0, 1'b0, 1'b0));
        // bimodal right, two-level wrong: chooser down, then pinned at zero
        dir_tab.push_back(row(CMD_RESOLVE, 64'h0, 1'b1, 16'h0001, 1'b1, 1'b0));
        dir_tab.push_back(row(CMD_RESOLVE, 64'h0, 1'b1, 16'h0001, 1'b1, 1'b0));
        dir_tab.push_back(row(CMD_RESOLVE, 64'h0, 1'b1, 16'h0000, 1'b1, 1'b1));
        dir_tab.push_back(row(CMD_PREDICT, 64'h0, 1'b0, 16'h0, 1'b0, 1'b0));
        // all-ones address folds onto slot 0
        dir_tab.push_back(row(CMD_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'hFFFF,
                              1'b0, 1'b1));
        // not-taken saturation at zero
        dir_tab.push_back(row(CMD_RESOLVE, 64'h55, 1'b0, 16'h0055, 1'b0, 1'b0));
        dir_tab.push_back(row(CMD_RESOLVE, 64'h55, 1'b0, 16'h0055, 1'b0, 1'b0));
        dir_tab.push_back(row(CMD_RESOLVE, 64'h55, 1'b0, 16'h0055, 1'b0, 1'b0));
        dir_tab.push_back(row(CMD_PREDICT, 64'h55, 1'b0, 16'h0, 1'b0, 1'b0));
        // two-level right: chooser up to strong, then pinned at three
        dir_tab.push_back(row(CMD_RESOLVE, 64'h1234, 1'b1, 16'hABCD, 1'b0, 1'b1));
        dir_tab.push_back(row(CMD_RESOLVE, 64'h1234, 1'b1, 16'hABCD, 1'b0, 1'b1));
        dir_tab.push_back(row(CMD_RESOLVE, 64'h1234, 1'b1, 16'hABCD, 1'b0, 1'b1));
        dir_tab.push_back(row(CMD_PREDICT, 64'h1234, 1'b0, 16'h0, 1'b0, 1'b0));
        dir_tab.push_back(row(CMD_RESOLVE, 64'h8000_0000_0000_0000, 1'b1, 16'hFFFF,
                              1'b1, 1'b1));
        dir_tab.push_back(row(CMD_PREDICT, 64'h8000_0000_0000_0000, 1'b0, 16'h0,
                              1'b0, 1'b0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register is writable while the counter tables are still being cleared
        apb_write(HIST_MODE_ADDR, 32'h0000_0001);
        apb_check_mode();

        foreach (dir_tab[n])
        begin
            pace_sender();
            offer(dir_tab[n]);
        end
        drain_results();

        // concatenated indexing; upper data bits and the spare address are ignored
        apb_write(HIST_MODE_ADDR, 32'hFFFF_FFFE);
        apb_write(SPARE_REG_ADDR, 32'hFFFF_FFFF);
        apb_check_mode();
        random_phase(350, 200);

        apb_write(HIST_MODE_ADDR, 32'h0000_0001);
        apb_check_mode();
        random_phase(350, -1);

        apb_write(HIST_MODE_ADDR, 32'h0000_0000);
        apb_check_mode();
        random_phase(350, -1);

        // closing stretch at full rate on both sides
        apb_write(HIST_MODE_ADDR, 32'hFFFF_FFFF);
        apb_check_mode();
        no_idle = 1'b1;
        random_phase(375, -1);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && due_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
